// ===== hw/rtl/uniform_grid_linear_interp_core_macros.svh =====
// Assertion macros shared by the interpolator RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef UNIFORM_GRID_LINEAR_INTERP_CORE_MACROS_SVH
`define UNIFORM_GRID_LINEAR_INTERP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define UGLI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define UGLI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UGLI_ASSERT_IMP(lbl, ante, cons, msg)
`define UGLI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/ugli_pkg.sv =====
// Types and constants of the uniform grid interpolator.
// No dependencies.
package ugli_pkg;

	localparam int DATA_W    = 32;
	localparam int STEP_W    = 31;
	localparam int COUNT_W   = 7;
	localparam int IDX_W     = 6;
	localparam int OC_W      = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_X     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd2;

	localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd65536;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [OC_W-1:0] OC_INTERP = 3'd0;
	localparam logic [OC_W-1:0] OC_HIT    = 3'd1;
	localparam logic [OC_W-1:0] OC_LOW    = 3'd2;
	localparam logic [OC_W-1:0] OC_HIGH   = 3'd3;
	localparam logic [OC_W-1:0] OC_MID    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPAN,
		S_EDGE,
		S_CLASS,
		S_DIVK,
		S_RDK,
		S_RDK1,
		S_DY,
		S_MUL,
		S_DIVQ,
		S_FIN,
		S_DONE
	} ugli_state_t;

endpackage

// ===== hw/rtl/ugli_req_if.sv =====
// Request channel of the interpolator: load and query items.
// Depends on ugli_pkg.
interface ugli_req_if import ugli_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [IDX_W-1:0]         point_index;
	logic signed [DATA_W-1:0] y_load;
	logic signed [DATA_W-1:0] query_x;
	logic                     x_is_number;

	modport source (output valid, cmd, point_index, y_load, query_x, x_is_number,
		input ready);
	modport sink (input valid, cmd, point_index, y_load, query_x, x_is_number,
		output ready);
endinterface

// ===== hw/rtl/ugli_rsp_if.sv =====
// Result channel of the interpolator.
// Depends on ugli_pkg.
interface ugli_rsp_if import ugli_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] y_value;
	logic signed [DATA_W-1:0] x_used;
	logic [OC_W-1:0]          outcome;

	modport source (output valid, y_value, x_used, outcome, input ready);
	modport sink (input valid, y_value, x_used, outcome, output ready);
endinterface

// ===== hw/rtl/ugli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ugli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/uniform_grid_linear_interp_core.sv =====
// Piecewise linear interpolator over a uniform grid, signed Q16.16. Grid point i sits at
// first_x + step_size*i; only the y values live in a MAX_POINTS deep RAM, written by load
// items (no result; indexes at or above MAX_POINTS are dropped). A query item gives one
// result: y_value, x_used and outcome (interpolated, grid hit, clamped low/high, midpoint).
// One item is worked at a time; a load is written on acceptance. A midpoint or clamp
// query skips the shared 32-step restoring divider; a grid hit uses it once, for the grid
// index, and an interpolated query once more, for the scaled fraction. A new item is taken
// while the previous result waits in the output register. Table entries read before being
// written return unspecified data.
// Depends on ugli_pkg, ugli_req_if, ugli_rsp_if, ugli_ram and the assertion macros.
`include "uniform_grid_linear_interp_core_macros.svh"

module uniform_grid_linear_interp_core import ugli_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]     cfg_data,
	ugli_req_if.sink              req,
	ugli_rsp_if.source            rsp
);
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int SPW = STEP_W + AW;  // step * (n-1)
	localparam int XW  = SPW + 2;      // first_x + span, signed

	// configuration
	logic signed [DATA_W-1:0] fx_q;
	logic [STEP_W-1:0]        step_q;
	logic [COUNT_W-1:0]       count_q;

	ugli_state_t state_q, state_n;

	// query datapath
	logic signed [DATA_W-1:0] qx_q;
	logic                     num_q;
	logic [SPW-1:0]           span_q;
	logic signed [DATA_W-1:0] y0_q, ya_q;
	logic signed [XW-1:0]     xfin_q, xmid_q;
	logic [AW-1:0]            k_q;
	logic [STEP_W-1:0]        rr_q;
	logic                     dneg_q;
	logic [DATA_W-1:0]        mag_q;

	// shared divider: {rem_q, quo_q} / step_q, 32 steps
	logic [STEP_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [4:0]        cnt_q;
	logic [DATA_W:0]   div_t;
	logic              div_ge;
	logic [STEP_W-1:0] rem_n;
	logic [DATA_W-1:0] quo_n;

	// result staging and output register
	logic [DATA_W-1:0] res_y_q, res_x_q;
	logic [OC_W-1:0]   res_oc_q;
	logic [DATA_W-1:0] out_y_q, out_x_q;
	logic [OC_W-1:0]   out_oc_q;
	logic              out_vld_q;

	// RAM
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic [AW-1:0] nm1;
	logic          req_acc, push;
	logic          cls_mid, cls_low, cls_high, cls_zstep;
	logic signed [XW-1:0]     qx_w, fx_w;
	logic signed [DATA_W:0]   dq;
	logic signed [DATA_W:0]   mid_dy, mid_half;
	logic signed [DATA_W+1:0] mid_y;
	logic signed [DATA_W:0]   dy;
	logic signed [DATA_W+1:0] fin_y;

	function automatic logic [DATA_W-1:0] sat_x(input logic signed [XW-1:0] v);
		logic [XW-DATA_W:0] hi;
		hi = v[XW-1:DATA_W-1];
		if (hi == '0 || hi == '1) begin
			return v[DATA_W-1:0];
		end
		return v[XW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

	// effective point count minus one
	always_comb begin
		if (count_q == '0) begin
			nm1 = '0;
		end else if (32'(count_q) > MAX_POINTS) begin
			nm1 = AW'(MAX_POINTS - 1);
		end else begin
			nm1 = AW'(count_q - 7'd1);
		end
	end

	assign req_acc = req.valid && req.ready;
	assign push    = (state_q == S_DONE) && (!out_vld_q || rsp.ready);

	// query classification
	assign qx_w      = XW'(qx_q);
	assign fx_w      = XW'(fx_q);
	assign cls_mid   = !num_q;
	assign cls_low   = qx_q < fx_q;
	assign cls_high  = qx_w > xfin_q;
	assign cls_zstep = (step_q == '0);
	assign dq        = (DATA_W+1)'(qx_q) - (DATA_W+1)'(fx_q);

	// midpoint y, halving truncated toward zero
	assign mid_dy   = (DATA_W+1)'($signed(ram_rdata)) - (DATA_W+1)'(y0_q);
	assign mid_half = (mid_dy + $signed((DATA_W+1)'(mid_dy[DATA_W]))) >>> 1;
	assign mid_y    = (DATA_W+2)'(y0_q) + (DATA_W+2)'(mid_half);

	assign dy    = (DATA_W+1)'($signed(ram_rdata)) - (DATA_W+1)'(ya_q);
	assign fin_y = dneg_q ? (DATA_W+2)'(ya_q) - (DATA_W+2)'({1'b0, quo_q})
	                      : (DATA_W+2)'(ya_q) + (DATA_W+2)'({1'b0, quo_q});

	// divider step
	assign div_t  = {1'b0, rem_q, quo_q[DATA_W-1]};
	assign div_ge = div_t >= {2'b0, step_q};
	assign rem_n  = div_ge ? STEP_W'(div_t - {2'b0, step_q}) : STEP_W'(div_t);
	assign quo_n  = {quo_q[DATA_W-2:0], div_ge};

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc && req.cmd == CMD_QUERY) begin
					state_n = S_SPAN;
				end
			end
			S_SPAN:  state_n = S_EDGE;
			S_EDGE:  state_n = S_CLASS;
			S_CLASS: begin
				if (cls_mid || cls_low || cls_high || cls_zstep) begin
					state_n = S_DONE;
				end else begin
					state_n = S_DIVK;
				end
			end
			S_DIVK: begin
				if (cnt_q == '0) begin
					state_n = S_RDK;
				end
			end
			S_RDK:   state_n = S_RDK1;
			S_RDK1:  state_n = (rr_q == '0) ? S_DONE : S_DY;
			S_DY:    state_n = S_MUL;
			S_MUL:   state_n = S_DIVQ;
			S_DIVQ: begin
				if (cnt_q == '0) begin
					state_n = S_FIN;
				end
			end
			S_FIN:   state_n = S_DONE;
			S_DONE: begin
				if (push) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_SPAN: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_EDGE: begin
				ram_re    = 1'b1;
				ram_raddr = nm1;
			end
			S_RDK: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
			end
			S_RDK1: begin
				ram_re    = 1'b1;
				ram_raddr = k_q + AW'(1);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// loads write straight on acceptance
	assign ram_we    = req_acc && (req.cmd == CMD_LOAD) && (32'(req.point_index) < MAX_POINTS);
	assign ram_waddr = AW'(req.point_index);

	ugli_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_POINTS)
	) u_ytab (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.y_load),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			fx_q      <= '0;
			step_q    <= STEP_RESET;
			count_q   <= COUNT_RESET;
		end else begin
			state_q <= state_n;
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_X:     fx_q    <= $signed(cfg_data);
					CFG_STEP_SIZE:   step_q  <= cfg_data[STEP_W-1:0];
					CFG_POINT_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (push) begin
			out_y_q  <= res_y_q;
			out_x_q  <= res_x_q;
			out_oc_q <= res_oc_q;
		end
		case (state_q)
			S_IDLE: begin
				qx_q  <= req.query_x;
				num_q <= req.x_is_number;
			end
			S_SPAN: begin
				span_q <= {{AW{1'b0}}, step_q} * {{STEP_W{1'b0}}, nm1};
			end
			S_EDGE: begin
				y0_q   <= $signed(ram_rdata);
				xfin_q <= fx_w + $signed({2'b0, span_q});
				xmid_q <= fx_w + $signed({3'b0, span_q[SPW-1:1]});
			end
			S_CLASS: begin
				// ram_rdata holds y[n-1] here
				if (cls_mid) begin
					res_x_q  <= sat_x(xmid_q);
					res_y_q  <= mid_y[DATA_W-1:0];
					res_oc_q <= OC_MID;
				end else if (cls_low) begin
					res_x_q  <= fx_q;
					res_y_q  <= y0_q;
					res_oc_q <= OC_LOW;
				end else if (cls_high) begin
					res_x_q  <= sat_x(xfin_q);
					res_y_q  <= ram_rdata;
					res_oc_q <= OC_HIGH;
				end else begin
					res_x_q  <= qx_q;
					res_y_q  <= y0_q;
					res_oc_q <= OC_HIT;
				end
				rem_q <= '0;
				quo_q <= dq[DATA_W-1:0];
				cnt_q <= 5'd31;
			end
			S_DIVK: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					k_q  <= quo_n[AW-1:0];
					rr_q <= rem_n;
				end
			end
			S_RDK1: begin
				ya_q    <= $signed(ram_rdata);
				res_y_q <= ram_rdata;
				if (rr_q == '0) begin
					res_oc_q <= OC_HIT;
				end
			end
			S_DY: begin
				dneg_q <= dy[DATA_W];
				mag_q  <= dy[DATA_W] ? DATA_W'(-dy) : DATA_W'(dy);
			end
			S_MUL: begin
				{rem_q, quo_q} <= {{STEP_W{1'b0}}, mag_q} * {{DATA_W{1'b0}}, rr_q};
				cnt_q          <= 5'd31;
			end
			S_DIVQ: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q - 5'd1;
			end
			S_FIN: begin
				if (fin_y[DATA_W+1:DATA_W-1] == '0 || fin_y[DATA_W+1:DATA_W-1] == '1) begin
					res_y_q <= fin_y[DATA_W-1:0];
				end else begin
					res_y_q <= fin_y[DATA_W+1] ? 32'h8000_0000 : 32'h7fff_ffff;
				end
				res_oc_q <= OC_INTERP;
			end
			default: ;
		endcase
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.y_value = out_y_q;
	assign rsp.x_used  = out_x_q;
	assign rsp.outcome = out_oc_q;

	`UGLI_ASSERT_NXT(a_load_no_work, req_acc && req.cmd == CMD_LOAD, state_q == S_IDLE, "load item started a query")
	`UGLI_ASSERT_IMP(a_fin_bound, state_q == S_FIN, quo_q <= mag_q, "fraction quotient exceeds span")
	`UGLI_ASSERT_IMP(a_out_from_done, $rose(out_vld_q), $past(state_q) == S_DONE, "result without query")
	`UGLI_ASSERT_NXT(a_div_runs, state_q == S_DIVK && cnt_q != '0, state_q == S_DIVK, "divider cut short")
endmodule

// ===== sim/ugli_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker of the uniform grid interpolator: watches config writes and both
// channels, predicts each query result and compares it. Depends on ugli_pkg and the interfaces.
module ugli_result_checker import ugli_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	ugli_req_if.sink             req_mon,
	ugli_rsp_if.sink             rsp_mon,
	output int                   pending,
	output int                   failures,
	output int                   queries_seen
);
	localparam int MAX_POINTS = 64;

	typedef struct packed {
		logic [DATA_W-1:0] y_value;
		logic [DATA_W-1:0] x_used;
		logic [OC_W-1:0]   outcome;
	} interp_result_t;

	interp_result_t expected_results[$];
	longint         grid_x0;
	longint         grid_step;
	int             grid_points;
	longint         y_entries [MAX_POINTS];

	function automatic logic [DATA_W-1:0] clip32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[DATA_W-1:0];
	endfunction

	function automatic interp_result_t interpolate(longint qx, logic is_num);
		interp_result_t res;
		longint n, x_end, y_first, y_last, yv, xu, d, k, r, ya, dy;
		logic [63:0] mag, q;
		n = grid_points;
		if (n < 1) n = 1;
		if (n > MAX_POINTS) n = MAX_POINTS;
		x_end = grid_x0 + grid_step * (n - 1);
		y_first = y_entries[0];
		y_last = y_entries[n-1];
		if (!is_num) begin
			xu = grid_x0 + (x_end - grid_x0) / 2;
			yv = y_first + (y_last - y_first) / 2;
			res.outcome = OC_MID;
		end else if (qx < grid_x0) begin
			xu = grid_x0;
			yv = y_first;
			res.outcome = OC_LOW;
		end else if (qx > x_end) begin
			xu = x_end;
			yv = y_last;
			res.outcome = OC_HIGH;
		end else begin
			xu = qx;
			d = qx - grid_x0;
			if (grid_step == 0) begin
				yv = y_first;
				res.outcome = OC_HIT;
			end else begin
				k = d / grid_step;
				r = d % grid_step;
				if (r == 0) begin
					yv = y_entries[k];
					res.outcome = OC_HIT;
				end else begin
					ya = y_entries[k];
					dy = y_entries[k+1] - ya;
					mag = (dy < 0) ? -dy : dy;
					q = (mag * r) / grid_step;
					yv = (dy < 0) ? ya - longint'(q) : ya + longint'(q);
					res.outcome = OC_INTERP;
				end
			end
		end
		res.y_value = clip32(yv);
		res.x_used = clip32(xu);
		return res;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		interp_result_t want;
		if (!arst_n) begin
			grid_x0 <= 0;
			grid_step <= STEP_RESET;
			grid_points <= COUNT_RESET;
			failures <= 0;
			queries_seen <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_X:     grid_x0 <= longint'($signed(cfg_data));
					CFG_STEP_SIZE:   grid_step <= longint'(cfg_data[STEP_W-1:0]);
					CFG_POINT_COUNT: grid_points <= int'(cfg_data[COUNT_W-1:0]);
					default: ;
				endcase
			end
			if (req_mon.valid && req_mon.ready) begin
				if (req_mon.cmd == CMD_LOAD)
					y_entries[req_mon.point_index] = longint'(req_mon.y_load);
				else begin
					expected_results.push_back(interpolate(longint'(req_mon.query_x),
						req_mon.x_is_number));
					queries_seen <= queries_seen + 1;
				end
			end
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_results.size() == 0) begin
					$display("%t: unexpected result y=%h x=%h oc=%0d", $time,
						rsp_mon.y_value, rsp_mon.x_used, rsp_mon.outcome);
					failures <= failures + 1;
				end else begin
					want = expected_results.pop_front();
					if (rsp_mon.y_value !== want.y_value || rsp_mon.x_used !== want.x_used ||
						rsp_mon.outcome !== want.outcome) begin
						$display("%t: mismatch expected y=%h x=%h oc=%0d, got y=%h x=%h oc=%0d",
							$time, want.y_value, want.x_used, want.outcome,
							rsp_mon.y_value, rsp_mon.x_used, rsp_mon.outcome);
						failures <= failures + 1;
					end
				end
			end
		end
	end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Top of the interpolator testbench: clock, reset, config phases and item stimulus.
// Depends on ugli_pkg, the channel interfaces, ugli_result_checker and the core.
module tb;
	import ugli_pkg::*;

	localparam int  MAX_POINTS  = 64;
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  DRAIN_WAIT  = 200;   // outlasts the slowest query
	localparam int  PHASE_ITEMS = 171;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	int                   pending, failures, queries_seen;
	int                   cycles;
	int                   send_gap_pct, recv_stall_pct;
	longint               cur_x0, cur_step;
	int                   cur_n;

	ugli_req_if req ();
	ugli_rsp_if rsp ();

	uniform_grid_linear_interp_core #(.MAX_POINTS(MAX_POINTS)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	ugli_result_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_mon(req.sink), .rsp_mon(rsp.sink),
		.pending(pending), .failures(failures), .queries_seen(queries_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk)
		rsp.ready = ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [DATA_W-1:0] clip32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[DATA_W-1:0];
	endfunction

	// Present one item and hold it until the core takes it. Valid stays high
	// into the next item unless the sender idles.
	task automatic send_item(logic cmd, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] yl,
		logic [DATA_W-1:0] qx, logic is_num);
		while ($urandom_range(99) < send_gap_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.cmd = cmd;
		req.point_index = idx;
		req.y_load = yl;
		req.query_x = qx;
		req.x_is_number = is_num;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic load_y(int idx, logic [DATA_W-1:0] y);
		send_item(CMD_LOAD, idx[IDX_W-1:0], y, $urandom(), 1'($urandom_range(1)));
	endtask

	task automatic query_at(longint x, logic is_num = 1'b1);
		send_item(CMD_QUERY, IDX_W'($urandom_range(63)), $urandom(), clip32(x), is_num);
	endtask

	// Config writes happen only with the core idle: all results in, then a
	// pause in case a load is still being retired.
	task automatic settle();
		req.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_grid(longint x0, longint step, int n);
		settle();
		write_reg(CFG_FIRST_X, x0[DATA_W-1:0]);
		write_reg(CFG_STEP_SIZE, step[DATA_W-1:0]);
		write_reg(CFG_POINT_COUNT, n[DATA_W-1:0]);
		cur_x0 = x0;
		cur_step = step;
		cur_n = (n < 1) ? 1 : (n > MAX_POINTS) ? MAX_POINTS : n;
	endtask

	function automatic logic [DATA_W-1:0] rand_y();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(2000) - 1000;
			default: return $urandom();
		endcase
	endfunction

	// Mostly queries aimed at the grid: hits, points inside a segment, small offsets
	// around a grid point; some fully random x and some midpoint requests; the rest loads.
	task automatic random_item();
		longint base, off;
		int k;
		if ($urandom_range(99) < 25) begin
			load_y($urandom_range(MAX_POINTS-1), rand_y());
		end else if ($urandom_range(99) < 8) begin
			query_at($signed($urandom()), 1'b0);
		end else begin
			k = $urandom_range(cur_n - 1);
			base = cur_x0 + cur_step * k;
			case ($urandom_range(6))
				0, 1: off = 0;
				2, 3, 4: off = (cur_step > 1) ? $urandom_range(cur_step - 1) : 0;
				5: off = -longint'($urandom_range(3)) + longint'($urandom_range(3));
				default: begin
					base = longint'($signed($urandom()));
					off = 0;
				end
			endcase
			query_at(base + off);
		end
	endtask

	initial begin
		longint x0s [8];
		longint steps [8];
		int     counts [8];
		req.valid = 1'b0;
		req.cmd = CMD_LOAD;
		req.point_index = '0;
		req.y_load = '0;
		req.query_x = '0;
		req.x_is_number = 1'b1;
		rsp.ready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = CFG_FIRST_X;
		cfg_data = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		cur_x0 = 0;
		cur_step = STEP_RESET;
		cur_n = COUNT_RESET;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the whole table first, so no query ever reads an unwritten entry.
		for (int i = 0; i < MAX_POINTS; i++)
			load_y(i, $urandom());

		// Directed part on the reset grid (x0 = 0, h = 1.0, two points).
		load_y(0, 32'h80000000);
		load_y(1, 32'h7FFFFFFF);
		load_y(MAX_POINTS - 1, 32'h00010000);
		query_at(-1);                       // clamp low
		query_at(-64'sd2147483648);         // most negative x
		query_at(64'sd2147483647);          // clamp high, most positive x
		query_at(0);                        // grid hit, first point
		query_at(65536);                    // grid hit, last point
		query_at(32768);                    // interpolated across full range
		query_at(1);                        // smallest fraction
		query_at(65535);                    // largest fraction
		query_at(0, 1'b0);                  // midpoint
		load_y(0, 32'h7FFFFFFF);
		load_y(1, 32'h80000000);
		query_at(32768);                    // falling segment
		query_at(12345, 1'b0);
		// Unknown register index: must be ignored.
		settle();
		write_reg(2'd3, $urandom());
		query_at(98304);

		// Random phases over several grids, extremes included.
		x0s    = '{0, -64'sd2147483648, 64'sd2147483647, -64'sd1000000, 12345,
			-64'sd65536, 64'sd100000, -64'sd2000000000};
		steps  = '{65536, 1, 64'sd2147483647, 3000, 0, 64'sd100000000, 7, 64'sd40000000};
		counts = '{64, 2, 1, 0, 5, 127, 64, 33};
		for (int p = 0; p < 8; p++) begin
			set_grid(x0s[p], steps[p], counts[p]);
			case (p % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 56; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 56; end
				default: begin send_gap_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// second half of each phase runs without idling or back-pressure
				if (i == PHASE_ITEMS / 2) begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				random_item();
			end
		end

		settle();
		$display("Covered %0d queries over 9 grid settings (first x, step and count extremes,",
			queries_seen);
		$display("zero step, point count 0 and above the table size) in %0d cycles", cycles);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
